FILE: design/napbc_pkg.sv
// shared constants, types and the cosine table of the all-pole biquad cascade
// used by napbc_mul, napbc_sqrt and the top level; no dependencies
`default_nettype none

package napbc_pkg;

	localparam int POLES     = 3;
	localparam int JW        = (POLES > 1) ? $clog2(POLES) : 1;
	localparam int HW        = JW + 1;

	localparam int ONE_Q16   = 65536;
	localparam int ANGLE_MAX = 411566;
	localparam int OUT_CLIP  = 6553600;
	localparam int TURN_K    = 667544;
	localparam int TINY_Q32  = 4295;
	localparam int GAIN_MAX  = 131072;
	localparam int STAB_LIM  = 65536;
	// floor(m / 1000) == (m * RECIP_K) >> RECIP_SH for m up to STAB_LIM
	localparam int RECIP_K   = 134218;
	localparam int RECIP_SH  = 27;

	localparam logic [47:0] HIST_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [40:0] TG_MAX   = 41'h100_0000_0000;

	localparam int MA_W   = 49;
	localparam int MB_W   = 23;
	localparam int MQ_W   = 55;
	localparam int RAW_W  = 54;
	localparam int SQ_W   = 57;
	localparam int ROOT_W = 29;

	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_NORM = 2'd1;
	localparam logic [1:0] REG_TRIM = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PHASE,
		ST_INTERP,
		ST_RC,
		ST_RR,
		ST_BC,
		ST_UU,
		ST_UC,
		ST_UCK,
		ST_KK,
		ST_TG,
		ST_SQRT,
		ST_BLEND,
		ST_GAIN,
		ST_SCALE,
		ST_FA,
		ST_FB,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [MA_W-1:0]  a;
		logic signed [MB_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [MQ_W-1:0]  q;
		logic [RAW_W-1:0]        raw;
	} mul_rsp_t;

	typedef struct packed {
		logic                    done;
		logic [ROOT_W-1:0]       root;
	} sqrt_rsp_t;

	// quarter-wave cosine, steps of pi/32
	function automatic logic [16:0] cos_tab(input logic [4:0] s);
		logic [16:0] v;
		case (s)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd65220;
			5'd2:    v = 17'd64277;
			5'd3:    v = 17'd62714;
			5'd4:    v = 17'd60547;
			5'd5:    v = 17'd57798;
			5'd6:    v = 17'd54491;
			5'd7:    v = 17'd50660;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd41576;
			5'd10:   v = 17'd36410;
			5'd11:   v = 17'd30893;
			5'd12:   v = 17'd25080;
			5'd13:   v = 17'd19024;
			5'd14:   v = 17'd12785;
			5'd15:   v = 17'd6424;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: design/napbc_mul.sv
// shared q16 multiplier: 48 x 22 bit magnitudes in two partial products
// depends on napbc_pkg; result rounds to nearest, ties away from zero
`default_nettype none

module napbc_mul (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire napbc_pkg::mul_req_t req,
	output napbc_pkg::mul_rsp_t      rsp
);

	logic [47:0]                       ma_q;
	logic [21:0]                       mb_q;
	logic                              neg_q;
	logic [45:0]                       lo_q;
	logic [45:0]                       hi_q;
	logic [1:0]                        step_q;
	logic                              busy_q;
	logic                              done_q;
	logic signed [napbc_pkg::MQ_W-1:0] q_q;
	logic [napbc_pkg::RAW_W-1:0]       raw_q;
	logic [48:0]                       a_abs;
	logic [22:0]                       b_abs;
	logic [69:0]                       full;
	logic [69:0]                       rnd;

	assign a_abs = req.a[48] ? 49'(-req.a) : 49'(req.a);
	assign b_abs = req.b[22] ? 23'(-req.b) : 23'(req.b);
	assign full  = {hi_q, 24'd0} + 70'(lo_q);
	assign rnd   = full + 70'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= a_abs[47:0];
			mb_q  <= b_abs[21:0];
			neg_q <= req.a[48] ^ req.b[22];
		end else if (busy_q) begin
			case (step_q)
				2'd0: lo_q <= 46'(ma_q[23:0]) * 46'(mb_q);
				2'd1: hi_q <= 46'(ma_q[47:24]) * 46'(mb_q);
				default: begin
					q_q   <= neg_q ? -$signed({1'b0, rnd[69:16]}) : $signed({1'b0, rnd[69:16]});
					raw_q <= full[69:16];
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;
	assign rsp.raw  = raw_q;

endmodule

`default_nettype wire

FILE: design/napbc_sqrt.sv
// iterative integer square root, one result bit per cycle
// depends on napbc_pkg; operand below 2^57
`default_nettype none

module napbc_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [napbc_pkg::SQ_W-1:0] v,
	output napbc_pkg::sqrt_rsp_t           rsp
);

	logic [napbc_pkg::SQ_W-1:0] v_q;
	logic [napbc_pkg::SQ_W-1:0] res_q;
	logic [napbc_pkg::SQ_W-1:0] bit_q;
	logic [napbc_pkg::SQ_W-1:0] trial;
	logic                       busy_q;
	logic                       done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v;
			res_q <= '0;
			bit_q <= {1'b1, {(napbc_pkg::SQ_W-1){1'b0}}};
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q[napbc_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: design/normalized_all_pole_biquad_cascade_unit.sv
// three-section all-pole biquad resonator with normalizing gain, q16
// depends on napbc_pkg, napbc_mul and napbc_sqrt
//
// input channel: in_valid / in_stall with sample_in, radius_0..2, angle_0..2;
// a transaction is taken when in_valid is high and in_stall low. in_stall is
// high from the cycle after a transaction until the result is in the output
// register. output channel: out_valid / out_stall with sample_out, held while
// out_stall is high. the apb port writes input_gain (0x0), norm_amount (0x4)
// and stability_trim (0x8); write registers only while the block is idle.
// one item needs 75 q16 products on the one shared multiplier, each taken
// in steps (issue, two partial products, rounding, take), plus a
// bit-serial square root and the handoff between the units.
// the next item is accepted as soon as the result is loaded, even while
// out_stall holds it; if the previous result is still waiting, the new
// result waits in the last step. reset clears the filter history, the
// registers go to their defaults and both channels go idle.
`default_nettype none

module normalized_all_pole_biquad_cascade_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [20:0] sample_in,
	input  wire logic signed [18:0] radius_0,
	input  wire logic signed [18:0] radius_1,
	input  wire logic signed [18:0] radius_2,
	input  wire logic signed [20:0] angle_0,
	input  wire logic signed [20:0] angle_1,
	input  wire logic signed [20:0] angle_2,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      sample_out
);

	localparam int P  = napbc_pkg::POLES;
	localparam int JW = napbc_pkg::JW;
	localparam int HW = napbc_pkg::HW;

	napbc_pkg::seq_state_t state_q, state_d;
	napbc_pkg::mul_req_t   mul_req;
	napbc_pkg::mul_rsp_t   mul_rsp;
	napbc_pkg::sqrt_rsp_t  sqrt_rsp;

	logic [17:0] gain_cfg_q;
	logic [16:0] norm_cfg_q;
	logic [17:0] trim_cfg_q;
	logic        cfg_wr;

	logic [17:0] gain_c;
	logic [16:0] norm_c;
	logic [17:0] trim_mag;
	logic [16:0] stab_mag;
	logic [34:0] stab_prod;
	logic [7:0]  stab_div;
	logic [16:0] maxrad_c;

	logic               wait_q;
	logic               sqrt_start;
	logic [JW-1:0]      i_q;
	logic [JW-1:0]      j_q;
	logic               j_last;
	logic               i_last;
	logic               in_acc;
	logic               out_load;
	logic               out_valid_q;
	logic signed [23:0] sample_out_q;

	logic signed [20:0] smp_q;
	logic signed [18:0] rad_q [P];
	logic signed [20:0] ang_q [P];
	logic [16:0]        maxrad_q;
	logic [4:0]         seg_q;
	logic [15:0]        frac_q;
	logic               cneg_q;
	logic signed [17:0] c_q;
	logic signed [17:0] cw_q [P];
	logic signed [23:0] ca_q [P];
	logic signed [23:0] cb_q [P];
	logic signed [23:0] k_q;
	logic signed [23:0] uc_q;
	logic signed [27:0] term_q;
	logic [40:0]        tg_q;
	logic [40:0]        g_q;
	logic [napbc_pkg::ROOT_W-1:0] root_q;
	logic signed [31:0] blend_q;
	logic signed [57:0] x_q;
	logic signed [47:0] hist_q [2*P];

	logic signed [18:0] rad_cur;
	logic signed [18:0] mr;
	logic signed [18:0] r_cur;
	logic signed [20:0] ang_cur;
	logic [18:0]        w_cur;
	logic signed [23:0] ca_cur;
	logic signed [23:0] cb_cur;
	logic signed [17:0] cw_i;
	logic signed [23:0] u_cur;
	logic [HW-1:0]      hidx;
	logic signed [47:0] hist_rd;
	logic signed [napbc_pkg::MQ_W-1:0] mq;
	logic [21:0]        phase;
	logic [20:0]        uq;
	logic signed [17:0] cmag;
	logic signed [napbc_pkg::MQ_W-1:0] tsum;
	logic [40:0]        tg_new;
	logic signed [57:0] y_raw;
	logic signed [57:0] y_clip;
	logic signed [23:0] out_clip;
	logic [napbc_pkg::SQ_W-1:0] sqrt_v;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_cfg_q <= 18'(napbc_pkg::ONE_Q16);
			norm_cfg_q <= '0;
			trim_cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				napbc_pkg::REG_GAIN: gain_cfg_q <= pwdata[17:0];
				napbc_pkg::REG_NORM: norm_cfg_q <= pwdata[16:0];
				napbc_pkg::REG_TRIM: trim_cfg_q <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			napbc_pkg::REG_GAIN: prdata = 32'(gain_cfg_q);
			napbc_pkg::REG_NORM: prdata = 32'(norm_cfg_q);
			napbc_pkg::REG_TRIM: prdata = 32'(trim_cfg_q);
			default:             prdata = '0;
		endcase
	end

	// clipped register values and radius limit
	assign gain_c    = (gain_cfg_q > 18'(napbc_pkg::GAIN_MAX)) ?
		18'(napbc_pkg::GAIN_MAX) : gain_cfg_q;
	assign norm_c    = (norm_cfg_q > 17'(napbc_pkg::ONE_Q16)) ?
		17'(napbc_pkg::ONE_Q16) : norm_cfg_q;
	assign trim_mag  = trim_cfg_q[17] ? 18'(-$signed(trim_cfg_q)) : trim_cfg_q;
	assign stab_mag  = (trim_mag > 18'(napbc_pkg::STAB_LIM)) ?
		17'(napbc_pkg::STAB_LIM) : trim_mag[16:0];
	assign stab_prod = 35'(stab_mag) * 35'(napbc_pkg::RECIP_K);
	assign stab_div  = stab_prod[napbc_pkg::RECIP_SH +: 8];
	assign maxrad_c  = trim_cfg_q[17] ? 17'(napbc_pkg::ONE_Q16) - 17'(stab_div) :
		17'(napbc_pkg::ONE_Q16) + 17'(stab_div);

	// operand selection
	assign rad_cur = rad_q[j_q];
	assign mr      = $signed({2'b00, maxrad_q});
	assign r_cur   = (rad_cur > mr) ? mr : ((rad_cur < -mr) ? -mr : rad_cur);
	assign ang_cur = ang_q[j_q];
	assign w_cur   = ang_cur[20] ? 19'd0 :
		((ang_cur > 21'(napbc_pkg::ANGLE_MAX)) ? 19'(napbc_pkg::ANGLE_MAX) : ang_cur[18:0]);
	assign ca_cur  = ca_q[j_q];
	assign cb_cur  = cb_q[j_q];
	assign cw_i    = cw_q[i_q];
	assign u_cur   = 24'sd65536 - cb_cur;
	assign hidx    = (state_q == napbc_pkg::ST_FB) ? {j_q, 1'b1} : {j_q, 1'b0};
	assign hist_rd = hist_q[hidx];
	assign mq      = mul_rsp.q;

	// cosine: quadrant fold, then table segment and fraction
	assign phase = mul_rsp.raw[21:0];
	assign uq    = phase[20] ? (21'h10_0000 - 21'(phase[19:0])) : 21'(phase[19:0]);
	assign cmag  = 18'(napbc_pkg::cos_tab(seg_q)) - 18'(mq);

	assign tsum   = 55'(term_q) + mq;
	assign tg_new = (mq > $signed(55'(napbc_pkg::TG_MAX))) ? napbc_pkg::TG_MAX : mq[40:0];
	assign y_raw  = x_q - 58'(mq);
	assign y_clip = (y_raw > $signed(58'(napbc_pkg::HIST_MAX))) ? $signed(58'(napbc_pkg::HIST_MAX)) :
		((y_raw < -$signed(58'(napbc_pkg::HIST_MAX))) ? -$signed(58'(napbc_pkg::HIST_MAX)) : y_raw);
	assign out_clip = (x_q > 58'sd6553600) ? 24'(napbc_pkg::OUT_CLIP) :
		((x_q < -58'sd6553600) ? -24'(napbc_pkg::OUT_CLIP) : 24'(x_q));
	assign sqrt_v = (g_q == '0) ? napbc_pkg::SQ_W'(napbc_pkg::TINY_Q32) : {g_q, 16'd0};

	assign j_last   = (j_q == JW'(P - 1));
	assign i_last   = (i_q == JW'(P - 1));
	assign in_acc   = in_valid & ~in_stall;
	assign out_load = (state_q == napbc_pkg::ST_OUT) & (~out_valid_q | ~out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			napbc_pkg::ST_IDLE:   if (in_valid) state_d = napbc_pkg::ST_PHASE;
			napbc_pkg::ST_PHASE:  if (mul_rsp.done) state_d = napbc_pkg::ST_INTERP;
			napbc_pkg::ST_INTERP: if (mul_rsp.done) state_d = napbc_pkg::ST_RC;
			napbc_pkg::ST_RC:     if (mul_rsp.done) state_d = napbc_pkg::ST_RR;
			napbc_pkg::ST_RR: begin
				if (mul_rsp.done)
					state_d = j_last ? napbc_pkg::ST_BC : napbc_pkg::ST_PHASE;
			end
			napbc_pkg::ST_BC:     if (mul_rsp.done) state_d = napbc_pkg::ST_UU;
			napbc_pkg::ST_UU:     if (mul_rsp.done) state_d = napbc_pkg::ST_UC;
			napbc_pkg::ST_UC:     if (mul_rsp.done) state_d = napbc_pkg::ST_UCK;
			napbc_pkg::ST_UCK:    if (mul_rsp.done) state_d = napbc_pkg::ST_KK;
			napbc_pkg::ST_KK:     if (mul_rsp.done) state_d = napbc_pkg::ST_TG;
			napbc_pkg::ST_TG: begin
				if (mul_rsp.done)
					state_d = (j_last && i_last) ? napbc_pkg::ST_SQRT : napbc_pkg::ST_BC;
			end
			napbc_pkg::ST_SQRT:   if (sqrt_rsp.done) state_d = napbc_pkg::ST_BLEND;
			napbc_pkg::ST_BLEND:  if (mul_rsp.done) state_d = napbc_pkg::ST_GAIN;
			napbc_pkg::ST_GAIN:   if (mul_rsp.done) state_d = napbc_pkg::ST_SCALE;
			napbc_pkg::ST_SCALE:  if (mul_rsp.done) state_d = napbc_pkg::ST_FA;
			napbc_pkg::ST_FA:     if (mul_rsp.done) state_d = napbc_pkg::ST_FB;
			napbc_pkg::ST_FB: begin
				if (mul_rsp.done)
					state_d = j_last ? napbc_pkg::ST_OUT : napbc_pkg::ST_FA;
			end
			napbc_pkg::ST_OUT:    if (out_load) state_d = napbc_pkg::ST_IDLE;
			default:              state_d = napbc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and unit starts
	always_comb begin
		in_stall      = (state_q != napbc_pkg::ST_IDLE);
		sqrt_start    = (state_q == napbc_pkg::ST_SQRT) & ~wait_q;
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (state_q)
			napbc_pkg::ST_PHASE: begin
				mul_req.a = 49'(w_cur);
				mul_req.b = 23'(napbc_pkg::TURN_K);
			end
			napbc_pkg::ST_INTERP: begin
				mul_req.a = seg_q[4] ? '0 :
					49'(napbc_pkg::cos_tab(seg_q) - napbc_pkg::cos_tab(seg_q + 5'd1));
				mul_req.b = 23'(frac_q);
			end
			napbc_pkg::ST_RC: begin
				mul_req.a = 49'(r_cur);
				mul_req.b = 23'(c_q);
			end
			napbc_pkg::ST_RR: begin
				mul_req.a = 49'(r_cur);
				mul_req.b = 23'(r_cur);
			end
			napbc_pkg::ST_BC: begin
				mul_req.a = 49'(cb_cur);
				mul_req.b = 23'(cw_i);
			end
			napbc_pkg::ST_UU: begin
				mul_req.a = 49'(u_cur);
				mul_req.b = 23'(u_cur);
			end
			napbc_pkg::ST_UC: begin
				mul_req.a = 49'(u_cur);
				mul_req.b = 23'(cw_i);
			end
			napbc_pkg::ST_UCK: begin
				mul_req.a = 49'(uc_q);
				mul_req.b = 23'(k_q);
			end
			napbc_pkg::ST_KK: begin
				mul_req.a = 49'(k_q);
				mul_req.b = 23'(k_q);
			end
			napbc_pkg::ST_TG: begin
				mul_req.a = 49'(tg_q);
				mul_req.b = 23'(term_q);
			end
			napbc_pkg::ST_BLEND: begin
				mul_req.a = 49'(root_q);
				mul_req.b = 23'(norm_c);
			end
			napbc_pkg::ST_GAIN: begin
				mul_req.a = 49'(smp_q);
				mul_req.b = 23'(gain_c);
			end
			napbc_pkg::ST_SCALE: begin
				mul_req.a = 49'(blend_q);
				mul_req.b = 23'(x_q);
			end
			napbc_pkg::ST_FA: begin
				mul_req.a = 49'(hist_rd);
				mul_req.b = 23'(ca_cur);
			end
			napbc_pkg::ST_FB: begin
				mul_req.a = 49'(hist_rd);
				mul_req.b = 23'(cb_cur);
			end
			default: ;
		endcase
		if (state_q != napbc_pkg::ST_IDLE && state_q != napbc_pkg::ST_SQRT &&
			state_q != napbc_pkg::ST_OUT)
			mul_req.start = ~wait_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= napbc_pkg::ST_IDLE;
			wait_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start || sqrt_start)
				wait_q <= 1'b1;
			else if (mul_rsp.done || sqrt_rsp.done)
				wait_q <= 1'b0;

			if (in_acc) begin
				j_q <= '0;
			end else if (mul_rsp.done) begin
				case (state_q)
					napbc_pkg::ST_RR, napbc_pkg::ST_TG, napbc_pkg::ST_FB:
						j_q <= j_last ? '0 : j_q + JW'(1);
					napbc_pkg::ST_SCALE: j_q <= '0;
					default: ;
				endcase
				if (state_q == napbc_pkg::ST_RR && j_last)
					i_q <= '0;
				else if (state_q == napbc_pkg::ST_TG && j_last)
					i_q <= i_last ? '0 : i_q + JW'(1);
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 2 * P; n++)
				hist_q[n] <= '0;
		end else if (state_q == napbc_pkg::ST_FB && mul_rsp.done) begin
			hist_q[{j_q, 1'b1}] <= hist_q[{j_q, 1'b0}];
			hist_q[{j_q, 1'b0}] <= 48'(y_clip);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q    <= sample_in;
			rad_q[0] <= radius_0;
			rad_q[1] <= radius_1;
			rad_q[2] <= radius_2;
			ang_q[0] <= angle_0;
			ang_q[1] <= angle_1;
			ang_q[2] <= angle_2;
			maxrad_q <= maxrad_c;
		end
		if (sqrt_rsp.done)
			root_q <= sqrt_rsp.root;
		if (out_load)
			sample_out_q <= out_clip;
		if (mul_rsp.done) begin
			case (state_q)
				napbc_pkg::ST_PHASE: begin
					seg_q  <= uq[20:16];
					frac_q <= uq[15:0];
					cneg_q <= phase[21] ^ phase[20];
				end
				napbc_pkg::ST_INTERP: begin
					c_q       <= cneg_q ? -cmag : cmag;
					cw_q[j_q] <= cneg_q ? -cmag : cmag;
				end
				napbc_pkg::ST_RC: ca_q[j_q] <= 24'(-(mq <<< 1));
				napbc_pkg::ST_RR: begin
					cb_q[j_q] <= 24'(mq);
					tg_q      <= 41'(napbc_pkg::ONE_Q16);
				end
				napbc_pkg::ST_BC:  k_q <= 24'(ca_cur + (mq <<< 1));
				napbc_pkg::ST_UU:  term_q <= 28'(mq);
				napbc_pkg::ST_UC:  uc_q <= 24'(mq);
				napbc_pkg::ST_UCK: term_q <= 28'(term_q + (mq <<< 1));
				napbc_pkg::ST_KK:  term_q <= tsum[54] ? '0 : 28'(tsum);
				napbc_pkg::ST_TG: begin
					if (j_last) begin
						tg_q <= 41'(napbc_pkg::ONE_Q16);
						if (i_q == '0 || tg_new < g_q)
							g_q <= tg_new;
					end else begin
						tg_q <= tg_new;
					end
				end
				napbc_pkg::ST_BLEND:
					blend_q <= 32'(32'sd65536 - $signed({15'd0, norm_c}) + mq);
				napbc_pkg::ST_GAIN:  x_q <= 58'(mq);
				napbc_pkg::ST_SCALE: x_q <= 58'(mq);
				napbc_pkg::ST_FA:    x_q <= y_raw;
				napbc_pkg::ST_FB:    x_q <= y_clip;
				default: ;
			endcase
		end
	end

	napbc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	napbc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.v      (sqrt_v),
		.rsp    (sqrt_rsp)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// one transaction in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input taken while an item is in flight");

	// a product only comes back when the sequencer waits for one
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> wait_q)
		else $error("multiplier result without a pending request");

	// shared units never started together
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && sqrt_start))
		else $error("multiplier and root started in the same cycle");

	// a new result only comes from the final step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == napbc_pkg::ST_OUT))
		else $error("output valid raised outside the output step");

endmodule

`default_nettype wire
